// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL files of the binary to decimal ASCII converter.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/b2da_pkg.sv =====
// Package of the binary to decimal ASCII converter: widths, constants, sizing function.
// Depends on nothing.
package b2da_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int DABBLE_STEPS    = 4;
	localparam int DIGIT_W         = 4;
	localparam int CHAR_W          = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Decimal digits needed for 2**w - 1: floor(w * log10(2)) + 1.
	function automatic int digits_for_width(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

endpackage

// ===== design/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_dabble, b2da_ser and assert_macros.svh.
//
//  channel | dir | handshake         | tdata / tuser                    | tlast
//  --------+-----+-------------------+----------------------------------+-------------
//  s_      | in  | s_tvalid/s_tready | value, byte padded               | -
//  m_      | out | m_tvalid/m_tready | digit_char [5:0], zero pad [7:6] | last digit
//
// The first character is presented once its input beat has passed the input register,
// one shift-and-add-3 stage per four value bits, and the serializer register.
// An item with n decimal digits holds the serializer for n characters (1 to 10 at 32 bits);
// the output port, at one character per cycle while m_tready is high, sets the sustained rate.
// Reset clears every valid bit and the serializer busy flag; payload is not reset.
// m_tready low holds the current character; the stages behind it fill, then s_tready drops.
module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // value, then zero padding
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,   // digit_char [5:0], zero [7:6]
	output logic                                m_tlast
);
	import b2da_pkg::*;
	`include "assert_macros.svh"

	localparam int DIGITS = digits_for_width(VALUE_WIDTH);
	localparam int BCD_W  = DIGITS * DIGIT_W;
	localparam int NSTAGE = (VALUE_WIDTH + DABBLE_STEPS - 1) / DABBLE_STEPS;

	// Input register: hold the value, bits above VALUE_WIDTH dropped.
	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] value_s1;

	// Chain between conversion stages; index 0 is the input register.
	logic [NSTAGE:0]        chain_valid;
	logic [NSTAGE:0]        chain_ready;
	logic [BCD_W-1:0]       chain_bcd [NSTAGE+1];
	logic [VALUE_WIDTH-1:0] chain_bin [NSTAGE+1];

	logic [CHAR_W-1:0]      out_char;

	assign s_tready = !valid_s1 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			value_s1 <= s_tdata[VALUE_WIDTH-1:0];
		end
	end

	assign chain_valid[0] = valid_s1;
	assign chain_bcd[0]   = '0;
	assign chain_bin[0]   = value_s1;

	// One stage per four value bits; the last stage takes what remains.
	for (genvar k = 0; k < NSTAGE; k++) begin : g_dabble
		localparam int STEPS_K = (k == NSTAGE - 1) ?
			(VALUE_WIDTH - (NSTAGE - 1) * DABBLE_STEPS) : DABBLE_STEPS;

		b2da_dabble #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.DIGITS      (DIGITS),
			.STEPS       (STEPS_K)
		) u_dabble (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_bcd    (chain_bcd[k]),
			.in_bin    (chain_bin[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_bcd   (chain_bcd[k+1]),
			.out_bin   (chain_bin[k+1])
		);
	end

	// Serializer: drop leading zeros, emit most significant digit first.
	b2da_ser #(
		.DIGITS (DIGITS)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[NSTAGE]),
		.in_ready  (chain_ready[NSTAGE]),
		.in_bcd    (chain_bcd[NSTAGE]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(8-CHAR_W){1'b0}}, out_char};

	// A presented character is always a decimal digit.
	`ASSERT_ALWAYS(a_char_range, clk, arst_n,
		!m_tvalid || (m_tdata[5:0] >= ASCII_ZERO && m_tdata[5:0] <= ASCII_ZERO + 6'd9),
		"output character outside '0' to '9'")

	// A run continues without a gap until its last beat.
	`ASSERT_NEXT(a_run_no_gap, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid,
		"run broke off before its last character")

endmodule

// ===== design/b2da_dabble.sv =====
// One register stage of the shift-and-add-3 binary to BCD conversion.
// Depends on b2da_pkg.
module b2da_dabble #(
	parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
	parameter int DIGITS      = b2da_pkg::digits_for_width(b2da_pkg::VALUE_WIDTH_DEF),
	parameter int STEPS       = b2da_pkg::DABBLE_STEPS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [DIGITS*b2da_pkg::DIGIT_W-1:0]  in_bcd,
	input  logic [VALUE_WIDTH-1:0]               in_bin,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [DIGITS*b2da_pkg::DIGIT_W-1:0]  out_bcd,
	output logic [VALUE_WIDTH-1:0]               out_bin
);
	import b2da_pkg::*;

	localparam int BCD_W = DIGITS * DIGIT_W;

	logic [BCD_W-1:0]       bcd_n;
	logic [VALUE_WIDTH-1:0] bin_n;
	logic                   valid_s1;
	logic [BCD_W-1:0]       bcd_s1;
	logic [VALUE_WIDTH-1:0] bin_s1;

	// Correct each digit, then shift in the next binary bit, msb first.
	always_comb begin
		bcd_n = in_bcd;
		bin_n = in_bin;
		for (int s = 0; s < STEPS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_n[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
					bcd_n[d*DIGIT_W +: DIGIT_W] = bcd_n[d*DIGIT_W +: DIGIT_W] + 4'd3;
				end
			end
			bcd_n = {bcd_n[BCD_W-2:0], bin_n[VALUE_WIDTH-1]};
			bin_n = bin_n << 1;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			bcd_s1 <= bcd_n;
			bin_s1 <= bin_n;
		end
	end

	assign out_valid = valid_s1;
	assign out_bcd   = bcd_s1;
	assign out_bin   = bin_s1;

endmodule

// ===== design/b2da_ser.sv =====
// Digit serializer: find the leading digit of a BCD word and emit one ASCII beat per cycle while out_ready is high.
// Depends on b2da_pkg.
module b2da_ser #(
	parameter int DIGITS = b2da_pkg::digits_for_width(b2da_pkg::VALUE_WIDTH_DEF)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [DIGITS*b2da_pkg::DIGIT_W-1:0]  in_bcd,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [b2da_pkg::CHAR_W-1:0]          out_char,
	output logic                                 out_last
);
	import b2da_pkg::*;

	localparam int BCD_W = DIGITS * DIGIT_W;
	localparam int IDX_W = $clog2(DIGITS);

	logic             busy_q;
	logic [BCD_W-1:0] bcd_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] lead;
	logic [DIGIT_W-1:0] cur_digit;

	// Highest nonzero digit; zero value keeps digit 0 so a single '0' goes out.
	always_comb begin
		lead = '0;
		for (int d = 1; d < DIGITS; d++) begin
			if (in_bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
				lead = IDX_W'(d);
			end
		end
	end

	assign out_last  = (idx_q == '0);
	assign in_ready  = !busy_q || (out_ready && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_ready) begin
			busy_q <= in_valid;
			idx_q  <= lead;
		end else if (out_ready) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			bcd_q <= in_bcd;
		end
	end

	assign cur_digit = bcd_q[idx_q*DIGIT_W +: DIGIT_W];
	assign out_valid = busy_q;
	assign out_char  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};

endmodule

// ===== tb/binary_to_decimal_ascii_tb.sv =====
// Testbench of binary_to_decimal_ascii: drives unsigned values and checks each ASCII digit beat.
// Depends on b2da_pkg and the binary_to_decimal_ascii RTL; self-checking, no external files.
module binary_to_decimal_ascii_tb;

	import b2da_pkg::*;

	localparam int VW          = VALUE_WIDTH_DEF;
	localparam int IN_W        = ((VW + 7) / 8) * 8;
	localparam int QUIET_LIMIT = 2000;   // cycles with no beat on either side
	localparam int TAIL_CYCLES = 30;     // drain time past the last expected digit
	localparam int RANDOM_ITEMS = 145;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
	} digit_beat_t;

	// Scoreboard: converts each accepted value into its expected digit beats and
	// checks every output beat against the oldest one.
	class digit_scoreboard;
		digit_beat_t digits_q[$];
		int unsigned mismatches;
		int unsigned values_noted;
		int unsigned chars_checked;
		int unsigned longest_run;

		function new();
			mismatches    = 0;
			values_noted  = 0;
			chars_checked = 0;
			longest_run   = 0;
		endfunction

		// Split the value into decimal digits, most significant first.
		function void note_value(input logic [VW-1:0] value);
			logic [VW-1:0] rest;
			logic [3:0]    rev [$];
			digit_beat_t   beat;
			int            n;
			rest = value;
			do begin
				rev.push_back(4'(rest % 10));
				rest = rest / 10;
			end while (rest != 0);
			n = rev.size();
			if (n > longest_run)
				longest_run = n;
			for (int k = n - 1; k >= 0; k--) begin
				beat.digit_char = ASCII_ZERO + CHAR_W'(rev[k]);
				beat.last       = (k == 0);
				digits_q.push_back(beat);
			end
			values_noted++;
		endfunction

		function void check_char(input logic [7:0] data, input logic last);
			digit_beat_t want;
			if (digits_q.size() == 0) begin
				$display("%0t: unexpected digit beat, expected none, actual data %h last %b",
					$time, data, last);
				mismatches++;
				return;
			end
			want = digits_q.pop_front();
			chars_checked++;
			if (data !== {2'b00, want.digit_char}) begin
				$display("%0t: digit mismatch, expected %h actual %h",
					$time, {2'b00, want.digit_char}, data);
				mismatches++;
			end
			if (last !== want.last) begin
				$display("%0t: last mismatch, expected %b actual %b", $time, want.last, last);
				mismatches++;
			end
		endfunction

		function int pending();
			return digits_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // value, then zero padding
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;   // digit_char [5:0], zero [7:6]
	logic             m_tlast;

	digit_scoreboard  book;
	int unsigned      stall_pct;   // chance in percent that a side idles in a cycle

	binary_to_decimal_ascii #(.VALUE_WIDTH(VW)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one value; random idle cycles go in front, tvalid stays high into the
	// next call so a back-to-back beat never sees tvalid dropped and raised in one step.
	task automatic send_value(input logic [VW-1:0] value);
		while ($urandom_range(99) < stall_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(value);
		do
			@(posedge clk);
		while (!s_tready);
		book.note_value(value);
	endtask

	// Pick a value: fully random bits, a random digit count, tiny numbers,
	// or a neighbor of a power of ten.
	function automatic logic [VW-1:0] random_value();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] p;
		int          n;
		case ($urandom_range(3))
			0: return $urandom;
			1: begin
				n  = $urandom_range(10, 1);
				lo = 1;
				for (int i = 1; i < n; i++)
					lo = lo * 10;
				hi = lo * 10 - 1;
				if (hi > 64'hFFFF_FFFF)
					hi = 64'hFFFF_FFFF;
				return VW'(lo + (64'($urandom) % (hi - lo + 1)));
			end
			2: return VW'($urandom_range(20));
			default: begin
				n = $urandom_range(9);
				p = 1;
				for (int i = 0; i < n; i++)
					p = p * 10;
				return VW'(p + 64'($urandom_range(2)) - 1);
			end
		endcase
	endfunction

	// Receive side: check every accepted digit beat, then decide on the next stall.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				book.check_char(m_tdata, m_tlast);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: end the run when neither side moves a beat for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin : main
		logic [VW-1:0] directed [$];
		book      = new();
		stall_pct = 10;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, single digits, power-of-ten boundaries around several of the
		// digit-count changes, full scale, and alternating bit patterns.
		directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
			32'd999, 32'd1000, 32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
			32'd999999999, 32'd1000000000, 32'd1000000001, 32'd1234567890,
			32'd2147483647, 32'd2147483648, 32'hAAAA_AAAA, 32'h5555_5555,
			32'd4294967294, 32'hFFFF_FFFF, 32'd0};
		foreach (directed[i])
			send_value(directed[i]);

		// Random: idle on both sides, then a long run with no idling, then idle again.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3)
				stall_pct = 0;
			else if (i == (2 * RANDOM_ITEMS) / 3)
				stall_pct = 10;
			send_value(random_value());
		end
		s_tvalid <= 1'b0;

		while (book.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d values and %0d digit beats, runs up to %0d digits",
			book.values_noted, book.chars_checked, book.longest_run);
		$display("zero, full scale, power-of-ten edges; stalls on both sides and a stall-free run");
		if (book.mismatches == 0 && book.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/b2da_pkg.sv
design/b2da_dabble.sv
design/b2da_ser.sv
design/binary_to_decimal_ascii.sv
tb/binary_to_decimal_ascii_tb.sv
